FILE: design/skset_pkg.sv
// Shared types and codes for the sorted key set.
`timescale 1ns / 1ps

package skset_pkg;

    localparam int KEY_W   = 32;
    localparam int OP_W    = 2;
    localparam int FIELD_W = 7;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [FIELD_W-1:0] position;
        logic [FIELD_W-1:0] entries;
        logic               full_reject;
    } t_out_item;

    // Per-cycle command broadcast along the cell row
    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_ENC,
        ST_UPD
    } t_state;

endpackage

FILE: design/skset_cell.sv
// One slot of the sorted key row: holds a key, compares, shifts with its neighbours.
`timescale 1ns / 1ps

module skset_cell #(
    parameter int KW = 32
) (
    input  logic                  i_clk,
    input  skset_pkg::t_cell_ctrl i_ctrl,
    input  logic                  i_occupied,
    input  logic [KW-1:0]         i_key,
    input  logic [KW-1:0]         i_left_key,
    input  logic [KW-1:0]         i_right_key,
    input  logic                  i_left_gt,
    output logic [KW-1:0]         o_key,
    output logic                  o_gt,
    output logic                  o_eq
);

    logic [KW-1:0] r_key;
    logic          r_gt;
    logic          r_eq;
    logic [KW-1:0] n_key;

    always_comb begin
        n_key = r_key;
        if (i_ctrl.ins && !r_gt) begin
            // first slot not greater than the key takes it, the rest move up
            n_key = i_left_gt ? i_key : i_left_key;
        end else if (i_ctrl.del && !r_gt) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        if (i_ctrl.cmp) begin
            r_gt <= i_occupied && (r_key > i_key);
            r_eq <= i_occupied && (r_key == i_key);
        end
    end

    assign o_key = r_key;
    assign o_gt  = r_gt;
    assign o_eq  = r_eq;

endmodule

FILE: design/sorted_key_set.sv
// Top level of the sorted key set: control sequencer, position encoder and the cell row.
// The result register is loaded in update, after the compare and encode states; update holds on a stall.
// A new item is accepted only in idle, after the previous one has updated; the row compares
// in parallel, then shifts by one slot in the update state.
// A waiting result does not block the next input transfer; a second result waits in update.
// Reset (synchronous, active low) empties the set and the result register; keys are not cleared.
`timescale 1ns / 1ps

module sorted_key_set #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  skset_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output skset_pkg::t_out_item o_out_data
);

    localparam int KW = (KEY_BITS < skset_pkg::KEY_W) ? KEY_BITS : skset_pkg::KEY_W;
    localparam int CW = $clog2(CAPACITY + 1);

    skset_pkg::t_state     r_state;
    skset_pkg::t_state     n_state;
    logic [skset_pkg::OP_W-1:0] r_op;
    logic [KW-1:0]         r_key;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_found;
    logic [CW-1:0]         r_pos;
    logic                  r_out_valid;
    skset_pkg::t_out_item  r_out;

    skset_pkg::t_cell_ctrl cell_ctrl;
    logic                  upd_go;
    logic                  do_ins;
    logic                  do_del;
    logic                  reject;
    logic                  out_free;

    logic [KW-1:0]         cell_key [CAPACITY];
    logic [CAPACITY-1:0]   cell_gt;
    logic [CAPACITY-1:0]   cell_eq;
    logic [CAPACITY:0]     bnd;
    logic [CW-1:0]         enc_pos;

    // Cell row
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KW-1:0] left_key;
        logic [KW-1:0] right_key;
        logic          left_gt;
        logic          occupied;

        if (g == 0) begin : g_first
            assign left_key = r_key;
            assign left_gt  = 1'b1;
        end else begin : g_mid
            assign left_key = cell_key[g-1];
            assign left_gt  = cell_gt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_key = r_key;
        end else begin : g_inner
            assign right_key = cell_key[g+1];
        end

        assign occupied = (CW'(g) < r_count);

        skset_cell #(
            .KW (KW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (cell_ctrl),
            .i_occupied  (occupied),
            .i_key       (r_key),
            .i_left_key  (left_key),
            .i_right_key (right_key),
            .i_left_gt   (left_gt),
            .o_key       (cell_key[g]),
            .o_gt        (cell_gt[g]),
            .o_eq        (cell_eq[g])
        );
    end

    // Greater-than bits form a run from slot 0; mark where it ends
    always_comb begin
        bnd[0] = !cell_gt[0];
        for (int i = 1; i < CAPACITY; i++) begin
            bnd[i] = cell_gt[i-1] && !cell_gt[i];
        end
        bnd[CAPACITY] = cell_gt[CAPACITY-1];
    end

    always_comb begin
        enc_pos = '0;
        for (int i = 0; i <= CAPACITY; i++) begin
            enc_pos = enc_pos | (CW'(i) & {CW{bnd[i]}});
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign reject   = (r_op == skset_pkg::OP_ADD) && !r_found && (r_count >= CW'(CAPACITY));
    assign do_ins   = (r_op == skset_pkg::OP_ADD) && !r_found && (r_count < CW'(CAPACITY));
    assign do_del   = (r_op == skset_pkg::OP_REMOVE) && r_found;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            skset_pkg::ST_IDLE: if (i_in_valid) n_state = skset_pkg::ST_CMP;
            skset_pkg::ST_CMP:  n_state = skset_pkg::ST_ENC;
            skset_pkg::ST_ENC:  n_state = skset_pkg::ST_UPD;
            skset_pkg::ST_UPD:  if (out_free) n_state = skset_pkg::ST_IDLE;
            default:            n_state = skset_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_stall    = 1'b1;
        upd_go        = 1'b0;
        cell_ctrl.cmp = 1'b0;
        unique case (r_state)
            skset_pkg::ST_IDLE: o_in_stall    = 1'b0;
            skset_pkg::ST_CMP:  cell_ctrl.cmp = 1'b1;
            skset_pkg::ST_ENC:  upd_go        = 1'b0;
            skset_pkg::ST_UPD:  upd_go        = out_free;
            default:            o_in_stall    = 1'b1;
        endcase
        cell_ctrl.ins = upd_go && do_ins;
        cell_ctrl.del = upd_go && do_del;
    end

    always_comb begin
        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + CW'(1);
        end else if (do_del) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= skset_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (upd_go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                // drop the result once transferred
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_op  <= i_in_data.op;
            r_key <= i_in_data.key[KW-1:0];
        end
        if (r_state == skset_pkg::ST_ENC) begin
            r_found <= |cell_eq;
            r_pos   <= enc_pos;
        end
        if (upd_go) begin
            r_out.found       <= r_found;
            r_out.position    <= skset_pkg::FIELD_W'(r_pos);
            r_out.entries     <= skset_pkg::FIELD_W'(n_count);
            r_out.full_reject <= reject;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: dv/skset_checker.sv
// Transfer monitor, sorted-set predictor and result comparison for the sorted key set.
`timescale 1ns / 1ps

module skset_checker
    import skset_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_item    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   i_out_data,
    output int unsigned o_fail_count,
    output int unsigned o_pending,
    output int unsigned o_results,
    output int unsigned o_hits,
    output int unsigned o_rejects
);

    localparam logic [KEY_W-1:0] KEY_MASK =
        (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} : ({KEY_W{1'b1}} >> (KEY_W - KEY_BITS));

    // Shadow set, strictly descending from index 0
    logic [KEY_W-1:0] set_keys [CAPACITY];
    int unsigned      set_size;
    t_out_item        pending_results [$];
    int unsigned      fails, results, hits, rejects;

    initial begin
        set_size = 0;
        fails    = 0;
        results  = 0;
        hits     = 0;
        rejects  = 0;
        o_fail_count = 0;
        o_pending    = 0;
        o_results    = 0;
        o_hits       = 0;
        o_rejects    = 0;
    end

    // Number of held keys strictly greater than k
    function automatic int unsigned slot_of(logic [KEY_W-1:0] k);
        int unsigned lo, hi, mid;
        lo = 0;
        hi = set_size;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (set_keys[mid] > k) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic t_out_item apply_to_set(t_in_item req);
        logic [KEY_W-1:0] k;
        int unsigned      pos;
        logic             hit;
        logic             reject;
        t_out_item        res;
        int               i;
        k      = req.key & KEY_MASK;
        pos    = slot_of(k);
        hit    = (pos < set_size) && (set_keys[pos] == k);
        reject = 1'b0;
        case (req.op)
            OP_ADD: begin
                if (!hit) begin
                    if (set_size >= CAPACITY) begin
                        reject = 1'b1;
                    end else begin
                        for (i = set_size; i > pos; i--) set_keys[i] = set_keys[i-1];
                        set_keys[pos] = k;
                        set_size++;
                    end
                end
            end
            OP_REMOVE: begin
                if (hit) begin
                    for (i = pos; i + 1 < set_size; i++) set_keys[i] = set_keys[i+1];
                    set_size--;
                end
            end
            // lookup and the spare code leave the set alone
            default: ;
        endcase
        res.found       = hit;
        res.position    = FIELD_W'(pos);
        res.entries     = FIELD_W'(set_size);
        res.full_reject = reject;
        return res;
    endfunction

    task automatic check_field(string name, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            set_size = 0;
            pending_results.delete();
        end else begin
            // retire the output side first: a result never belongs to a same-edge input
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result with no expectation waiting: %h", i_out_data);
                    fails++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("found", FIELD_W'(want.found), FIELD_W'(i_out_data.found));
                    check_field("position", want.position, i_out_data.position);
                    check_field("entries", want.entries, i_out_data.entries);
                    check_field("full_reject", FIELD_W'(want.full_reject),
                                FIELD_W'(i_out_data.full_reject));
                    results++;
                    if (want.found) hits++;
                    if (want.full_reject) rejects++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_results.push_back(apply_to_set(i_in_data));
            end
        end
        o_fail_count <= fails;
        o_pending    <= pending_results.size();
        o_results    <= results;
        o_hits       <= hits;
        o_rejects    <= rejects;
    end

endmodule

FILE: dv/testbench.sv
// Stimulus, flow control and verdict for the sorted key set.
`timescale 1ns / 1ps

module testbench;
    import skset_pkg::*;

    localparam int              CAPACITY   = 64;
    localparam int              KEY_BITS   = 32;
    localparam int              POOL_SIZE  = 96;
    localparam int              PHASES     = 10;
    localparam int              PHASE_LEN  = 170;
    localparam int              HOLD_PHASE = 4;
    localparam int              LONG_HOLD  = 300;
    localparam logic [OP_W-1:0] OP_SPARE   = 2'd3;

    typedef enum int {
        MIX_GROW,
        MIX_EVEN,
        MIX_SHRINK
    } t_mix;

    logic      clk      = 1'b0;
    logic      rst_n    = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_data  = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;
    logic      hold_req = 1'b0;

    int unsigned fail_count, pending, results, hits, rejects;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    always #6 clk = ~clk;

    sorted_key_set #(
        .CAPACITY(CAPACITY),
        .KEY_BITS(KEY_BITS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    skset_checker #(
        .CAPACITY(CAPACITY),
        .KEY_BITS(KEY_BITS)
    ) u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_results   (results),
        .o_hits      (hits),
        .o_rejects   (rejects)
    );

    function automatic t_in_item make_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
        t_in_item req;
        req.op  = op;
        req.key = key;
        return req;
    endfunction

    function automatic logic [OP_W-1:0] pick_op(t_mix mix);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_GROW: begin
                if (roll < 80) return OP_ADD;
                if (roll < 88) return OP_REMOVE;
                if (roll < 96) return OP_LOOKUP;
                return OP_SPARE;
            end
            MIX_SHRINK: begin
                if (roll < 10) return OP_ADD;
                if (roll < 85) return OP_REMOVE;
                if (roll < 95) return OP_LOOKUP;
                return OP_SPARE;
            end
            default: begin
                if (roll < 40) return OP_ADD;
                if (roll < 75) return OP_REMOVE;
                if (roll < 95) return OP_LOOKUP;
                return OP_SPARE;
            end
        endcase
    endfunction

    // Mostly pool keys so that hits, duplicates and a full set all occur
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 3) != 0) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    // Offer one item and hold it until the transfer
    task automatic send(t_in_item req);
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic idle(int cycles);
        if (cycles > 0) begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic drain();
        idle(1);
        while (pending != 0) @(posedge clk);
    endtask

    // Receiver flow control: random segments, plus one long hold-off on request
    initial begin
        int mode, len;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (LONG_HOLD) begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end else begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(5, 60);
                repeat (len) begin
                    case (mode)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 99) < 30);
                        2: out_stall <= ($urandom_range(0, 99) < 75);
                        default: out_stall <= ~out_stall;
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial begin
        #6_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        t_mix mix;
        int   burst;
        for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = {1'b1, {(KEY_W - 1){1'b0}}};
        key_pool[3] = {1'b0, {(KEY_W - 1){1'b1}}};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty set, key extremes, duplicates, misses, spare code, removals
        send(make_request(OP_LOOKUP, 32'h0000_0000));
        send(make_request(OP_REMOVE, 32'h0000_0005));
        send(make_request(OP_ADD,    32'h0000_0000));
        send(make_request(OP_ADD,    32'hFFFF_FFFF));
        send(make_request(OP_ADD,    32'h0000_0000));
        send(make_request(OP_ADD,    32'h8000_0000));
        send(make_request(OP_ADD,    32'h7FFF_FFFF));
        send(make_request(OP_ADD,    32'h0000_0001));
        send(make_request(OP_ADD,    32'hFFFF_FFFE));
        send(make_request(OP_LOOKUP, 32'hFFFF_FFFF));
        send(make_request(OP_LOOKUP, 32'h0000_0000));
        send(make_request(OP_LOOKUP, 32'h1234_5678));
        send(make_request(OP_SPARE,  32'hFFFF_FFFF));
        send(make_request(OP_SPARE,  32'h0000_0002));
        send(make_request(OP_REMOVE, 32'h1234_5678));
        send(make_request(OP_REMOVE, 32'hFFFF_FFFF));
        send(make_request(OP_REMOVE, 32'h0000_0000));
        send(make_request(OP_REMOVE, 32'h8000_0000));
        send(make_request(OP_ADD,    32'hFFFF_FFFF));
        send(make_request(OP_LOOKUP, 32'hAAAA_AAAA));
        send(make_request(OP_LOOKUP, 32'h5555_5555));
        send(make_request(OP_ADD,    32'h5555_5555));
        send(make_request(OP_REMOVE, 32'h0000_0001));
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase % 3)
                0: mix = MIX_GROW;
                1: mix = MIX_EVEN;
                default: mix = MIX_SHRINK;
            endcase
            // one phase runs flat out against a long receiver hold-off
            if (phase == HOLD_PHASE) hold_req = 1'b1;
            burst = $urandom_range(1, 24);
            for (int n = 0; n < PHASE_LEN; n++) begin
                send(make_request(pick_op(mix), pick_key()));
                if (phase != HOLD_PHASE) begin
                    burst--;
                    if (burst == 0) begin
                        idle($urandom_range(0, 12));
                        burst = $urandom_range(1, 24);
                    end
                end
            end
            drain();
        end

        repeat (20) @(posedge clk);
        $display("Covered %0d transfers of lookup, add, remove and the spare code,", results);
        $display("with %0d hits and %0d adds refused on a full set.", hits, rejects);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
